FILE: sv/ssr_pkg.sv
//==============================================================================
// ssr_pkg
// Shared types and constants for the streaming substring replace unit.
//==============================================================================
`default_nettype none

package ssr_pkg;

    // Byte and length widths
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 4;
    localparam int CFG_W    = 64;
    localparam int ADDR_W   = 5;

    // Default sizes of the pattern window and the replacement
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // Register map, one 64-bit register every 8 bytes
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } reg_idx_t;

    // Description of one emission job handed to the output sequencer:
    // cnt data bytes, then a bare end marker when tail is set
    typedef struct packed {
        logic             eos;
        logic             tail;
        logic [LEN_W-1:0] cnt;
    } job_info_t;

endpackage : ssr_pkg

`default_nettype wire

FILE: sv/ssr_cell.sv
//==============================================================================
// ssr_cell
// One window position: holds a byte, takes the incoming byte when selected,
// compares against its pattern byte and hands its byte to the left neighbor.
//==============================================================================
`default_nettype none

module ssr_cell
    import ssr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              upd_en,
    input  wire logic              shift_en,
    input  wire logic              sel,
    input  wire logic [DATA_W-1:0] in_byte,
    input  wire logic [DATA_W-1:0] nbr_ins,
    input  wire logic [DATA_W-1:0] pat_byte,
    output logic      [DATA_W-1:0] ins_byte,
    output logic                   eq
);

    logic [DATA_W-1:0] byte_reg;
    logic [DATA_W-1:0] byte_next;

    // Window content with the incoming byte placed at this position
    assign ins_byte = sel ? in_byte : byte_reg;
    assign eq       = (ins_byte == pat_byte);

    // Shift in from the right neighbor on a miss, else keep the merged byte
    always_comb
    begin
        byte_next = byte_reg;
        if (upd_en)
        begin
            byte_next = shift_en ? nbr_ins : ins_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule : ssr_cell

`default_nettype wire

FILE: sv/ssr_emit.sv
//==============================================================================
// ssr_emit
// Output sequencer: holds one emission job in a shift chain of bytes and
// drains it one result per transfer through a registered output stage.
//==============================================================================
`default_nettype none

module ssr_emit
    import ssr_pkg::*;
#(
    parameter int BUF_DEPTH = MAX_PATTERN_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire job_info_t                         load_info,
    input  wire logic [BUF_DEPTH-1:0][DATA_W-1:0]  load_bytes,
    output logic                                   load_ready,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [DATA_W-1:0]                 out_byte,
    output logic                                   out_has,
    output logic                                   out_last
);

    logic                             job_valid_reg, job_valid_next;
    logic [LEN_W-1:0]                 rem_reg, rem_next;
    logic                             eos_reg, eos_next;
    logic                             tail_reg, tail_next;
    logic [BUF_DEPTH-1:0][DATA_W-1:0] buf_reg, buf_next;

    logic                             out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]                out_byte_reg, out_byte_next;
    logic                             out_has_reg, out_has_next;
    logic                             out_last_reg, out_last_next;

    logic out_free;
    logic step;
    logic job_final;
    logic load_take;
    logic bare_now;

    // Handshake between job holder and output register
    assign out_free   = !out_valid_reg || out_ready;
    assign step       = job_valid_reg && out_free;
    assign job_final  = (rem_reg <= LEN_W'(1));
    assign load_ready = !job_valid_reg || (step && job_final);
    assign load_take  = load && ((load_info.cnt != '0) || load_info.tail);
    assign bare_now   = tail_reg && job_final;

    // Advance the job: load a new one or shift out one byte
    always_comb
    begin
        job_valid_next = job_valid_reg;
        rem_next       = rem_reg;
        eos_next       = eos_reg;
        tail_next      = tail_reg;
        buf_next       = buf_reg;
        if (load)
        begin
            job_valid_next = load_take;
            rem_next       = load_info.cnt + LEN_W'(load_info.tail);
            eos_next       = load_info.eos;
            tail_next      = load_info.tail;
            buf_next       = load_bytes;
        end
        else if (step)
        begin
            if (job_final)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                rem_next = rem_reg - LEN_W'(1);
                for (int k = 0; k < BUF_DEPTH - 1; k++)
                begin
                    buf_next[k] = buf_reg[k+1];
                end
                buf_next[BUF_DEPTH-1] = '0;
            end
        end
    end

    // Fill the output register from the head of the job
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_has_next   = !bare_now;
            out_byte_next  = bare_now ? '0 : buf_reg[0];
            out_last_next  = eos_reg && job_final;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rem_reg       <= '0;
            eos_reg       <= 1'b0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            rem_reg       <= rem_next;
            eos_reg       <= eos_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload holds without reset
    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_has   = out_has_reg;
    assign out_last  = out_last_reg;

endmodule : ssr_emit

`default_nettype wire

FILE: sv/stream_substring_replace_unit.sv
//==============================================================================
// stream_substring_replace_unit
// Streaming find-and-replace of a configured byte pattern.
//==============================================================================
// Bytes enter a row of window cells, one cell per pattern position, and the
// window is compared with the pattern in the cycle a byte fills it. A miss
// sends out the oldest byte, a match sends out the replacement and empties
// the window, and the last byte of a string flushes what remains, ending
// with tlast (a bare end marker with tuser low if nothing is left). The
// input takes one byte per cycle while the output accepts results and each
// byte yields at most one result; a byte that yields N results (a replacement
// of N bytes, a flush of up to MAX_PATTERN bytes, or either one followed by a
// bare end marker) holds s_axis_tready low while the output sequencer drains
// them. Results pass through the job register, then the output register.
// Write configuration only while the block is idle; writing pattern_length
// empties the window.
//==============================================================================
`default_nettype none

module stream_substring_replace_unit
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  wire logic              s_axis_tlast,   // end_of_string

    // Output stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [7:0]        m_axis_tdata,   // [7:0] out_byte
    output logic                   m_axis_tuser,   // [0] has_byte
    output logic                   m_axis_tlast,   // is_last

    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready
);

    localparam int BUF_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                : MAX_REPLACEMENT;
    localparam int FILL_W    = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [CFG_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [CFG_W-1:0] rep_bytes_reg;
    logic [LEN_W-1:0] rep_len_reg;

    logic [FILL_W-1:0] fill_reg, fill_next;

    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic             in_fire;
    logic [LEN_W-1:0] eff_m;
    logic [LEN_W-1:0] eff_r;
    logic [LEN_W-1:0] fill_ext;
    logic             compare;
    logic             match;

    logic [MAX_PATTERN-1:0]             eq_vec;
    logic [MAX_PATTERN-1:0]             act_vec;
    logic [MAX_PATTERN-1:0][DATA_W-1:0] ins_vec;

    job_info_t                        job_info;
    logic [BUF_DEPTH-1:0][DATA_W-1:0] job_bytes;
    logic                             load_ready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PATTERN_BYTES:      pat_bytes_reg <= pwdata;
                REG_PATTERN_LENGTH:     pat_len_reg   <= pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_reg <= pwdata;
                REG_REPLACEMENT_LENGTH: rep_len_reg   <= pwdata[LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (cfg_idx)
            REG_PATTERN_BYTES:      prdata = pat_bytes_reg;
            REG_PATTERN_LENGTH:     prdata = CFG_W'(pat_len_reg);
            REG_REPLACEMENT_BYTES:  prdata = rep_bytes_reg;
            REG_REPLACEMENT_LENGTH: prdata = CFG_W'(rep_len_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp lengths to the supported range
    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            eff_m = LEN_W'(1);
        end
        else if (pat_len_reg > LEN_W'(MAX_PATTERN))
        begin
            eff_m = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_m = pat_len_reg;
        end

        if (rep_len_reg > LEN_W'(MAX_REPLACEMENT))
        begin
            eff_r = LEN_W'(MAX_REPLACEMENT);
        end
        else
        begin
            eff_r = rep_len_reg;
        end
    end

    assign fill_ext = LEN_W'(fill_reg);
    assign compare  = ((fill_ext + LEN_W'(1)) == eff_m);

    // Row of window cells
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic [DATA_W-1:0] nbr;

        if (i == MAX_PATTERN - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = ins_vec[i+1];
        end

        assign act_vec[i] = (LEN_W'(i) < eff_m);

        ssr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .upd_en   (in_fire),
            .shift_en (compare && !match),
            .sel      (fill_reg == FILL_W'(i)),
            .in_byte  (s_axis_tdata),
            .nbr_ins  (nbr),
            .pat_byte (pat_bytes_reg[DATA_W*i +: DATA_W]),
            .ins_byte (ins_vec[i]),
            .eq       (eq_vec[i])
        );
    end

    assign match = compare && (&(eq_vec | ~act_vec));

    // Job bytes: the replacement on a match, else the window in order
    for (genvar k = 0; k < BUF_DEPTH; k++)
    begin : g_job
        logic [DATA_W-1:0] rep_b;
        logic [DATA_W-1:0] win_b;

        if (k < MAX_REPLACEMENT)
        begin : g_rep
            assign rep_b = rep_bytes_reg[DATA_W*k +: DATA_W];
        end
        else
        begin : g_norep
            assign rep_b = '0;
        end

        if (k < MAX_PATTERN)
        begin : g_win
            assign win_b = ins_vec[k];
        end
        else
        begin : g_nowin
            assign win_b = '0;
        end

        assign job_bytes[k] = match ? rep_b : win_b;
    end

    // Job size: replacement, one missed byte, or the flushed window; add a
    // bare end marker when the string ends with the window emptied
    always_comb
    begin
        job_info.eos  = s_axis_tlast;
        job_info.tail = 1'b0;
        if (match)
        begin
            job_info.cnt  = eff_r;
            job_info.tail = s_axis_tlast;
        end
        else if (compare)
        begin
            job_info.cnt  = s_axis_tlast ? eff_m : LEN_W'(1);
            job_info.tail = s_axis_tlast && (eff_m == LEN_W'(1));
        end
        else
        begin
            job_info.cnt = s_axis_tlast ? (fill_ext + LEN_W'(1)) : '0;
        end
    end

    // Window fill count
    always_comb
    begin
        fill_next = fill_reg;
        if (cfg_wr && (cfg_idx == REG_PATTERN_LENGTH))
        begin
            fill_next = '0;
        end
        else if (in_fire)
        begin
            if (s_axis_tlast || match)
            begin
                fill_next = '0;
            end
            else if (compare)
            begin
                fill_next = FILL_W'(eff_m - LEN_W'(1));
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign s_axis_tready = load_ready;

    ssr_emit #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .load_info  (job_info),
        .load_bytes (job_bytes),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_has    (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    // Window never holds a full pattern between items
    a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(eff_m))
        else $error("window fill reached pattern length");

    // A result without a byte is always the end marker and carries zero data
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("bare result is not a clean end marker");

    // End of string empties the window
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (fill_reg == '0))
        else $error("window not empty after end of string");

endmodule : stream_substring_replace_unit

`default_nettype wire

FILE: tb/tb_stream_substring_replace_unit.sv
//==============================================================================
// tb_stream_substring_replace_unit
// Self-checking bench for the streaming substring replace unit.
//==============================================================================
// Drives byte strings into the input stream and programs the pattern and
// replacement over the APB port. An in-bench model predicts every output
// transfer from the accepted input transfers. Each output transfer is
// compared field by field with the oldest prediction. A short directed part
// covers the length limits, deletion, the bare end marker and register writes
// made in the middle of a string. Random strings with planted full and
// partial matches follow, under three mixes of sender and receiver idling.
// One long receiver hold-off backs the unit up against its input.
//==============================================================================

module tb_stream_substring_replace_unit;
    import ssr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE_WAIT  = 6;
    localparam int ROUND_ITEMS  = 30;
    localparam int HOLD_CYCLES  = 250;

    // One output transfer: out_byte, has_byte and is_last
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       is_last;
    } emitted_t;

    // Tracks the rewrite of the string and the output it must produce
    class rewrite_tracker;
        logic [7:0]  win [8];
        int unsigned fill;
        logic [63:0] pat_bytes;
        logic [3:0]  pat_len;
        logic [63:0] rep_bytes;
        logic [3:0]  rep_len;
        emitted_t    pending_out [$];
        int          errors;

        function new();
            foreach (win[i])
                win[i] = 8'h00;
            fill      = 0;
            pat_bytes = '0;
            pat_len   = 4'd1;
            rep_bytes = '0;
            rep_len   = 4'd0;
            errors    = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_BYTES:      pat_bytes = value;
                REG_PATTERN_LENGTH:
                begin
                    pat_len = value[3:0];
                    fill    = 0;
                end
                REG_REPLACEMENT_BYTES:  rep_bytes = value;
                REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
                default: ;
            endcase
        endfunction

        function void push(logic [7:0] b, logic has, logic last);
            emitted_t e;
            e.out_byte = b;
            e.has_byte = has;
            e.is_last  = last;
            pending_out.push_back(e);
        endfunction

        // Shift one input byte through the window and predict its output
        function void take_byte(logic [7:0] b, logic eos);
            int unsigned m;
            int unsigned r;
            int unsigned i;
            bit          hit;
            m = (pat_len == 0) ? 1 : ((pat_len > 8) ? 8 : pat_len);
            r = (rep_len > 8) ? 8 : rep_len;
            win[fill] = b;
            fill++;
            if (fill == m)
            begin
                hit = 1'b1;
                for (i = 0; i < m; i++)
                    if (win[i] != pat_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (i = 0; i < r; i++)
                        push(rep_bytes[8*i +: 8], 1'b1, 1'b0);
                    fill = 0;
                end
                else
                begin
                    push(win[0], 1'b1, 1'b0);
                    for (i = 0; i + 1 < m; i++)
                        win[i] = win[i+1];
                    fill = m - 1;
                end
            end
            // Flush at end of string, or send a bare end marker
            if (eos)
            begin
                if (fill == 0)
                    push(8'h00, 1'b0, 1'b1);
                else
                    for (i = 0; i < fill; i++)
                        push(win[i], 1'b1, (i + 1 == fill));
                fill = 0;
            end
        endfunction

        function void compare_output(logic [7:0] b, logic has, logic last);
            emitted_t e;
            if (pending_out.size() == 0)
            begin
                $error("unexpected output transfer: out_byte=%0h has_byte=%0b is_last=%0b",
                       b, has, last);
                errors++;
                return;
            end
            e = pending_out.pop_front();
            if (b !== e.out_byte)
            begin
                $error("out_byte mismatch: expected %0h, actual %0h", e.out_byte, b);
                errors++;
            end
            if (has !== e.has_byte)
            begin
                $error("has_byte mismatch: expected %0b, actual %0b", e.has_byte, has);
                errors++;
            end
            if (last !== e.is_last)
            begin
                $error("is_last mismatch: expected %0b, actual %0b", e.is_last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_out.size();
        endfunction
    endclass

    // Clock, reset and ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic              s_axis_tlast = 1'b0;    // end_of_string
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;           // [7:0] out_byte
    logic              m_axis_tuser;           // [0] has_byte
    logic              m_axis_tlast;           // is_last
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0]  pwdata = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    rewrite_tracker tracker = new();

    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    int          items_sent = 0;
    logic [63:0] cur_pat = '0;
    int          cur_m = 1;

    stream_substring_replace_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Note accepted input transfers and check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tracker.compare_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Stop a run that no longer moves any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_stream_substring_replace_unit: errors");
            $finish;
        end
    end

    // Register write: setup cycle, access cycle, then release the bus
    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tracker.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop tvalid and let the unit drain before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic set_rules(logic [63:0] pat, logic [3:0] plen,
                             logic [63:0] rep, logic [3:0] rlen);
        wait_idle();
        apb_write(REG_PATTERN_BYTES, pat);
        apb_write(REG_PATTERN_LENGTH, {60'd0, plen});
        apb_write(REG_REPLACEMENT_BYTES, rep);
        apb_write(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
        cur_pat = pat;
        cur_m   = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);
    endtask

    // Offer one byte, with random sender gaps, until it is taken
    task automatic send_byte(logic [7:0] b, logic eos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return cur_pat[8*$urandom_range(cur_m-1) +: 8];
        else if (r < 50)
            return ($urandom_range(1) != 0) ? 8'h41 : 8'h42;
        else if (r < 60)
            return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // Build a string from planted matches, near misses and loose bytes
    task automatic send_string();
        logic [7:0] q [$];
        int         target;
        int         r;
        int         k;
        int         n;
        target = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
        while (q.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 35)
                for (k = 0; k < cur_m; k++)
                    q.push_back(cur_pat[8*k +: 8]);
            else if (r < 50 && cur_m > 1)
            begin
                n = $urandom_range(1, cur_m - 1);
                for (k = 0; k < n; k++)
                    q.push_back(cur_pat[8*k +: 8]);
            end
            else
                q.push_back(pick_byte());
        end
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    // Random rules, biased to the length limits and to repetitive patterns
    task automatic random_rules();
        logic [63:0] pat;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        int          k;
        pat = {$urandom, $urandom};
        if ($urandom_range(1) != 0)
            for (k = 0; k < 8; k++)
                pat[8*k +: 8] = ($urandom_range(1) != 0) ? 8'h41 : 8'h42;
        plen = ($urandom_range(9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(15));
        rlen = ($urandom_range(9) < 7) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
        set_rules(pat, plen, {$urandom, $urandom}, rlen);
    endtask

    initial
    begin
        int start;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset rules delete zero bytes; a deleted last byte ends bare
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);

        // Two-byte pattern with junk above it, replacement length saturates
        set_rules(64'hFFEE_DDCC_BBAA_0201, 4'd2, 64'h8877_6655_4433_2211, 4'd15);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);

        // Pattern length zero acts as one
        set_rules(64'h0000_0000_0000_55FF, 4'd0, 64'hFFFF_FFFF_FF80_7F00, 4'd3);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Pattern length saturates at eight, the whole string is deleted
        set_rules(64'h0123_4567_89AB_CDEF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        for (int k = 0; k < 8; k++)
            send_byte(cur_pat[8*k +: 8], k == 7);

        // Rewrite pattern length, then pattern bytes, in mid-string
        set_rules(64'h0000_0000_6463_6261, 4'd4, 64'h0000_0000_0000_0058, 4'd1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b0);
        wait_idle();
        apb_write(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h61, 1'b0);
        wait_idle();
        apb_write(REG_PATTERN_BYTES, 64'h0000_0000_0000_6361);
        send_byte(8'h63, 1'b1);

        // Random strings under three idling mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 18 : ((phase == 1) ? 47 : 0);
            sink_idle_pct = (phase == 0) ? 47 : ((phase == 1) ? 18 : 0);
            for (int round = 0; round < 4; round++)
            begin
                random_rules();
                if (phase == 2 && round == 1)
                    hold_req <= 1'b1;
                start = items_sent;
                while (items_sent - start < ROUND_ITEMS)
                    send_string();
            end
        end

        // Drain and report
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_stream_substring_replace_unit: clean");
        else
            $display("tb_stream_substring_replace_unit: errors");
        $finish;
    end

endmodule

FILE: stream_substring_replace_unit.f
sv/ssr_pkg.sv
sv/ssr_cell.sv
sv/ssr_emit.sv
sv/stream_substring_replace_unit.sv
tb/tb_stream_substring_replace_unit.sv
